@@ design/glls_pkg.sv @@
`timescale 1ns / 1ps

package glls_pkg;

  // Fixed field widths of the element and result formats.
  localparam int unsigned FIELD_W = 16;
  localparam int unsigned SCORE_W = 32;
  localparam int unsigned SUM_W = 48;
  localparam int unsigned SQ_W = 2 * FIELD_W;
  localparam int unsigned TERM_W = SQ_W + 1;

  // Steps of the shared restoring divider for one element term and for the final mean.
  localparam int unsigned TERM_STEPS = TERM_W;
  localparam int unsigned MEAN_STEPS = SUM_W;
  localparam int unsigned STEP_W = $clog2(MEAN_STEPS + 1);

  localparam int unsigned DEFAULT_MAX_ELEMENTS = 4096;

  // A zero variance code stands for 1.0 in unsigned Q2.14.
  localparam logic [FIELD_W-1:0] ONE_Q2_14 = 16'd16384;
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
  localparam logic [SUM_W-1:0] MEAN_LIMIT = 48'h0000_8000_0000;

endpackage

@@ design/gaussian_log_likelihood_score.sv @@
`timescale 1ns / 1ps

// Diagonal Gaussian log-likelihood scorer.
// Each transfer on the in_ channel carries one vector element: in_tdata holds the sample
// value, the model mean and the model variance, and in_tlast marks the final element.
// The block adds (value - mean)^2 / (2 * variance) to a 48-bit running sum, taking a
// zero variance as 1.0. After the last element it divides the sum by the element count
// and presents the negated mean as a signed Q16.16 score on the out_ channel, with
// out_tuser set when the sum, the element count or the score saturated.
// One shared restoring divider, one quotient bit per cycle, does all the division.
// A non-final element keeps in_tready low after its transfer through the multiply state,
// 33 divider steps and the accumulate state, so the next element waits until its term is
// summed. A last element then adds a load state, 48 divider steps and the emit state,
// which writes the result register once it is free and raises out_tvalid.
// Elements beyond MAX_ELEMENTS are dropped and flag saturation; a dropped element that
// is not last leaves in_tready high.
// The result register parts the two channels: the next vector's elements are taken
// while a score still waits, and only the write of the next score waits for out_tready.
// A synchronous active-low reset clears the sum, count, flag and out_tvalid, and idles the FSM.
module gaussian_log_likelihood_score #(
  parameter int unsigned MAX_ELEMENTS = glls_pkg::DEFAULT_MAX_ELEMENTS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // sample_value [15:0], model_mean [31:16], model_variance [47:32]
  input  logic [3*glls_pkg::FIELD_W-1:0]    in_tdata,
  input  logic                              in_tlast,   // last_element
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [glls_pkg::SCORE_W-1:0]      out_tdata,  // score [31:0]
  output logic                              out_tuser   // saturated
);
  import glls_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned DSR_W = (CNT_W > FIELD_W) ? CNT_W : FIELD_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_ACC,
    S_FLOAD,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;

  logic [FIELD_W-1:0] val_r, val_nxt;
  logic [FIELD_W-1:0] mean_r, mean_nxt;
  logic [FIELD_W-1:0] var_r, var_nxt;
  logic               last_r, last_nxt;
  logic               final_r, final_nxt;

  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               ovf_r, ovf_nxt;

  // Shared divider: dividend shifts out at the top while quotient bits shift in below.
  logic [SUM_W-1:0]   dvd_r, dvd_nxt;
  logic [DSR_W-1:0]   rem_r, rem_nxt;
  logic [DSR_W-1:0]   dsr_r, dsr_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [SCORE_W-1:0] score_r, score_nxt;
  logic               sat_r, sat_nxt;

  logic               in_xfer;
  logic               count_full;
  logic signed [FIELD_W:0] diff;
  logic [FIELD_W-1:0] abs_diff;
  logic [SQ_W-1:0]    square;
  logic [DSR_W:0]     shifted;
  logic               fits;
  logic [SUM_W:0]     sum_ext;
  logic [SUM_W-1:0]   mean_clamped;
  logic               mean_over;

  assign in_tready  = (state_r == S_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign count_full = (count_r >= CNT_W'(MAX_ELEMENTS));
  assign out_tvalid = out_valid_r;
  assign out_tdata  = score_r;
  assign out_tuser  = sat_r;

  // Exact deviation and its square; |diff| never exceeds 65535.
  assign diff     = $signed({val_r[FIELD_W-1], val_r}) - $signed({mean_r[FIELD_W-1], mean_r});
  assign abs_diff = diff[FIELD_W] ? FIELD_W'(-diff) : diff[FIELD_W-1:0];
  assign square   = abs_diff * abs_diff;

  // One restoring divider step.
  assign shifted = {rem_r, dvd_r[SUM_W-1]};
  assign fits    = (shifted >= {1'b0, dsr_r});

  assign sum_ext      = {1'b0, sum_r} + {{(SUM_W+1-TERM_W){1'b0}}, dvd_r[TERM_W-1:0]};
  assign mean_over    = (dvd_r > MEAN_LIMIT);
  assign mean_clamped = mean_over ? MEAN_LIMIT : dvd_r;

  always_comb begin
    state_nxt     = state_r;
    val_nxt       = val_r;
    mean_nxt      = mean_r;
    var_nxt       = var_r;
    last_nxt      = last_r;
    final_nxt     = final_r;
    sum_nxt       = sum_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    dsr_nxt       = dsr_r;
    step_nxt      = step_r;
    score_nxt     = score_r;
    sat_nxt       = sat_r;
    out_valid_nxt = out_valid_r && !out_tready;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          val_nxt  = in_tdata[FIELD_W-1:0];
          mean_nxt = in_tdata[2*FIELD_W-1:FIELD_W];
          var_nxt  = in_tdata[3*FIELD_W-1:2*FIELD_W];
          last_nxt = in_tlast;
          if (count_full) begin
            // The element is dropped but a last marker still closes the vector.
            ovf_nxt   = 1'b1;
            state_nxt = in_tlast ? S_FLOAD : S_IDLE;
          end else begin
            state_nxt = S_MUL;
          end
        end
      end
      S_MUL: begin
        // Numerator 2*D sits at the top so 33 steps leave the quotient in the low bits.
        dvd_nxt   = {square, 1'b0, {(SUM_W-TERM_W){1'b0}}};
        rem_nxt   = '0;
        dsr_nxt   = DSR_W'((var_r == '0) ? ONE_Q2_14 : var_r);
        step_nxt  = STEP_W'(TERM_STEPS);
        final_nxt = 1'b0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        rem_nxt  = fits ? DSR_W'(shifted - {1'b0, dsr_r}) : shifted[DSR_W-1:0];
        dvd_nxt  = {dvd_r[SUM_W-2:0], fits};
        step_nxt = step_r - 1'b1;
        if (step_r == STEP_W'(1)) begin
          state_nxt = final_r ? S_EMIT : S_ACC;
        end
      end
      S_ACC: begin
        if (sum_ext[SUM_W]) begin
          sum_nxt = SUM_MAX;
          ovf_nxt = 1'b1;
        end else begin
          sum_nxt = sum_ext[SUM_W-1:0];
        end
        count_nxt = count_r + 1'b1;
        state_nxt = last_r ? S_FLOAD : S_IDLE;
      end
      S_FLOAD: begin
        dvd_nxt   = sum_r;
        rem_nxt   = '0;
        dsr_nxt   = (count_r == '0) ? DSR_W'(1) : DSR_W'(count_r);
        step_nxt  = STEP_W'(MEAN_STEPS);
        final_nxt = 1'b1;
        state_nxt = S_DIV;
      end
      S_EMIT: begin
        if (!out_valid_r || out_tready) begin
          score_nxt     = SCORE_W'(0) - mean_clamped[SCORE_W-1:0];
          sat_nxt       = ovf_r || mean_over;
          out_valid_nxt = 1'b1;
          sum_nxt       = '0;
          count_nxt     = '0;
          ovf_nxt       = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sum_r       <= '0;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      final_r     <= 1'b0;
      step_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      final_r     <= final_nxt;
      step_r      <= step_nxt;
    end
    val_r   <= val_nxt;
    mean_r  <= mean_nxt;
    var_r   <= var_nxt;
    last_r  <= last_nxt;
    dvd_r   <= dvd_nxt;
    rem_r   <= rem_nxt;
    dsr_r   <= dsr_nxt;
    score_r <= score_nxt;
    sat_r   <= sat_nxt;
  end

  // The count never passes the configured vector length.
  assert property (@(posedge clk) disable iff (!rst_n) count_r <= CNT_W'(MAX_ELEMENTS))
    else $error("element count passed MAX_ELEMENTS");

  // The divider is never in its step state with no steps left.
  assert property (@(posedge clk) disable iff (!rst_n) (state_r == S_DIV) |-> (step_r != '0))
    else $error("divider running with zero steps");

  // A transfer that is summed or that closes a vector keeps the block busy next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
      (in_xfer && (!count_full || in_tlast)) |=> !in_tready)
    else $error("input accepted back to back");

  // Writing a fresh score clears the per-vector state at the same edge.
  assert property (@(posedge clk) disable iff (!rst_n)
      $rose(out_valid_r) |-> (count_r == '0 && sum_r == '0 && !ovf_r))
    else $error("vector state not cleared with result");

  // The divisor is never zero while dividing.
  assert property (@(posedge clk) disable iff (!rst_n) (state_r == S_DIV) |-> (dsr_r != '0))
    else $error("zero divisor in shared divider");

endmodule
